// ===== hw/rtl/dphd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphd_pkg
// Shared types and constants for the debounced press and hold detector.
// ----------------------------------------------------------------------------
package dphd_pkg;

    typedef struct packed {
        logic        pressed;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] countdown_seconds;
    } result_t;

    // Hold step outcome handed to the countdown stage.
    typedef struct packed {
        logic [1:0]  event_res;
        logic        active;
        logic [31:0] remain_ms;
    } mid_t;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_SHORT = 2'd1;
    localparam logic [1:0] EVT_HOLD  = 2'd2;

    localparam logic REG_HOLD_TIME     = 1'b0;
    localparam logic REG_DEBOUNCE_TIME = 1'b1;

    localparam logic [31:0] HOLD_TIME_RESET     = 32'd3000;
    localparam logic [31:0] DEBOUNCE_TIME_RESET = 32'd20;

    localparam int          CD_SHIFT     = 28;
    localparam logic [18:0] CD_RECIP     = 19'd268436;
    localparam logic [17:0] ROUND_UP     = 18'd999;
    localparam logic [31:0] SAT_LIMIT_MS = 32'd255000;
    localparam logic [7:0]  COUNT_MAX    = 8'd255;

endpackage

// ===== hw/rtl/dphd_countdown.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphd_countdown
// Converts remaining hold milliseconds to whole seconds, rounded up and
// saturated, using a reciprocal multiply in place of a divider.
// ----------------------------------------------------------------------------
module dphd_countdown
    import dphd_pkg::*;
(
    input  mid_t    mid,
    output result_t res
);

    logic [17:0] biased;
    logic [36:0] product;
    logic [7:0]  secs;

    assign biased  = mid.remain_ms[17:0] + ROUND_UP;
    assign product = 37'(biased) * 37'(CD_RECIP);

    always_comb
    begin
        if (!mid.active)
        begin
            secs = 8'd0;
        end
        else if (mid.remain_ms > SAT_LIMIT_MS)
        begin
            secs = COUNT_MAX;
        end
        else
        begin
            secs = product[CD_SHIFT +: 8];
        end
    end

    assign res.event_res         = mid.event_res;
    assign res.countdown_seconds = secs;

endmodule

// ===== hw/rtl/debounced_press_hold_detector_top.sv =====
`timescale 1ns / 1ps
// An accepted request passes in order through the input, middle and result registers.
// Throughput: one request per cycle; the three-register pipeline keeps
// taking requests while a result waits, until all three stages are full.
// Reset clears levels, timestamps, hold flag and stage valids, and loads
// hold_time_ms = 3000 and debounce_time_ms = 20.
// ----------------------------------------------------------------------------
// debounced_press_hold_detector_top
// Debounces a raw button level against a millisecond timestamp and reports
// short presses, hold completion and a seconds countdown to completion.
// ----------------------------------------------------------------------------
module debounced_press_hold_detector_top
    import dphd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] hold_time_reg;
    logic [31:0] debounce_time_reg;

    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic        fired_reg, fired_next;
    logic [31:0] edge_time_reg, edge_time_next;
    logic [31:0] press_time_reg, press_time_next;

    logic        a_valid_reg;
    item_t       a_reg;
    logic        b_valid_reg;
    mid_t        b_reg, b_next;
    logic        c_valid_reg;
    result_t     c_reg, c_next;

    logic        c_ready, b_ready, a_ready;
    logic        a_to_b, b_to_c;

    logic        stab_change;
    logic        fire;
    logic        fired_mid;
    logic [31:0] held;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg     <= HOLD_TIME_RESET;
            debounce_time_reg <= DEBOUNCE_TIME_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data;
                default:           hold_time_reg     <= hold_time_reg;
            endcase
        end
    end

    assign c_ready    = !c_valid_reg || result_ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign item_ready = a_ready;
    assign a_to_b     = a_valid_reg && b_ready;
    assign b_to_c     = b_valid_reg && c_ready;

    // State update for the request in the input register.
    always_comb
    begin
        raw_next       = a_reg.pressed;
        edge_time_next = (a_reg.pressed != raw_reg) ? a_reg.now_ms : edge_time_reg;
        stab_change    = (raw_next != stable_reg)
                         && ((a_reg.now_ms - edge_time_next) >= debounce_time_reg);
        stable_next    = stab_change ? raw_next : stable_reg;
        press_time_next = (stab_change && raw_next) ? a_reg.now_ms : press_time_reg;
        fired_mid      = (stab_change && raw_next) ? 1'b0 : fired_reg;
        held           = a_reg.now_ms - press_time_next;
        fire           = stable_next && raw_next && !fired_mid && (held >= hold_time_reg);
        fired_next     = fired_mid || fire;

        b_next.event_res = EVT_NONE;
        if (fire)
        begin
            b_next.event_res = EVT_HOLD;
        end
        else if (stab_change && !raw_next && !fired_reg)
        begin
            b_next.event_res = EVT_SHORT;
        end
        b_next.active    = stable_next && raw_next && !fired_mid && (held < hold_time_reg);
        b_next.remain_ms = hold_time_reg - held;
    end

    dphd_countdown u_countdown (
        .mid (b_reg),
        .res (c_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            fired_reg      <= 1'b0;
            edge_time_reg  <= 32'd0;
            press_time_reg <= 32'd0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            if (a_to_b)
            begin
                raw_reg        <= raw_next;
                stable_reg     <= stable_next;
                fired_reg      <= fired_next;
                edge_time_reg  <= edge_time_next;
                press_time_reg <= press_time_next;
            end
            if (a_ready)
            begin
                a_valid_reg <= item_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && item_valid)
        begin
            a_reg <= item;
        end
        if (a_to_b)
        begin
            b_reg <= b_next;
        end
        if (b_to_c)
        begin
            c_reg <= c_next;
        end
    end

    assign result_valid = c_valid_reg;
    assign result       = c_reg;

`ifndef NO_ASSERTIONS
    // A hold or short press always leaves the countdown inactive.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_res == EVT_HOLD || result.event_res == EVT_SHORT))
        |-> (result.countdown_seconds == 8'd0))
        else $error("countdown nonzero on a press event");

    // Requests are refused only when every pipeline stage holds a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (a_valid_reg && b_valid_reg && c_valid_reg))
        else $error("input refused with a free pipeline stage");

    // A middle-stage request is never dropped while the result stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && c_valid_reg && !result_ready) |=> b_valid_reg)
        else $error("middle stage lost a request under stall");

    // The hold state changes only when a request leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !a_to_b |=> ($stable(fired_reg) && $stable(press_time_reg)))
        else $error("hold state changed without a request");
`endif

endmodule

// ===== test/press_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_event_checker
// Watches the request, result and register write channels of the press and
// hold detector. It keeps its own copy of the debounce and hold state,
// predicts the event and countdown of every accepted request, and compares
// each accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module press_event_checker
    import dphd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int unsigned pending_events,
    output int unsigned mismatch_count
);

    localparam logic [32:0] MS_PER_SEC = 33'd1000;
    localparam logic [32:0] ROUND_BIAS = 33'd999;
    localparam int unsigned REPORT_MAX = 10;

    logic [31:0] hold_ms;
    logic [31:0] debounce_ms;
    logic        raw_lvl;
    logic        stable_lvl;
    logic        hold_done;
    logic [31:0] change_ms;
    logic [31:0] press_ms;
    result_t     expected_q[$];
    int unsigned errors;

    assign mismatch_count = errors;

    function automatic logic [7:0] seconds_left(input logic [31:0] now);
        logic [31:0] held;
        logic [32:0] secs;
        if (!stable_lvl || !raw_lvl || hold_done)
        begin
            return 8'd0;
        end
        held = now - press_ms;
        if (held >= hold_ms)
        begin
            return 8'd0;
        end
        secs = ({1'b0, hold_ms - held} + ROUND_BIAS) / MS_PER_SEC;
        return (secs > {25'd0, COUNT_MAX}) ? COUNT_MAX : secs[7:0];
    endfunction

    task automatic step_detector(input item_t req);
        result_t     want;
        logic [31:0] steady;
        logic [31:0] held;
        want.event_res = EVT_NONE;
        if (req.pressed != raw_lvl)
        begin
            raw_lvl   = req.pressed;
            change_ms = req.now_ms;
        end
        steady = req.now_ms - change_ms;
        if (raw_lvl != stable_lvl && steady >= debounce_ms)
        begin
            stable_lvl = raw_lvl;
            if (stable_lvl)
            begin
                press_ms  = req.now_ms;
                hold_done = 1'b0;
            end
            else if (!hold_done)
            begin
                want.event_res = EVT_SHORT;
            end
        end
        held = req.now_ms - press_ms;
        if (stable_lvl && raw_lvl && !hold_done && held >= hold_ms)
        begin
            hold_done      = 1'b1;
            want.event_res = EVT_HOLD;
        end
        want.countdown_seconds = seconds_left(req.now_ms);
        expected_q.push_back(want);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
            begin
                $display("unexpected result: event %0d countdown %0d",
                         got.event_res, got.countdown_seconds);
            end
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res ||
                got.countdown_seconds !== want.countdown_seconds)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("result mismatch: expected event %0d countdown %0d, got event %0d countdown %0d",
                             want.event_res, want.countdown_seconds,
                             got.event_res, got.countdown_seconds);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms     = HOLD_TIME_RESET;
            debounce_ms = DEBOUNCE_TIME_RESET;
            raw_lvl     = 1'b0;
            stable_lvl  = 1'b0;
            hold_done   = 1'b0;
            change_ms   = '0;
            press_ms    = '0;
            expected_q.delete();
            errors      = 0;
            pending_events <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HOLD_TIME)
                begin
                    hold_ms = cfg_data;
                end
                else
                begin
                    debounce_ms = cfg_data;
                end
            end
            if (item_valid && item_ready)
            begin
                step_detector(item);
            end
            if (result_valid && result_ready)
            begin
                check_result(result);
            end
            pending_events <= expected_q.size();
        end
    end

endmodule

// ===== test/debounced_press_hold_detector_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_press_hold_detector_top_test
// Drives button samples with timestamps into the detector: a directed run
// over debounce, hold, wrap and countdown saturation cases, then random
// bounce, press and release sequences under several timing settings and
// idling patterns. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module debounced_press_hold_detector_top_test;
    import dphd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_HOLD_TIME;
    logic [31:0] cfg_data = '0;
    int unsigned pending_events;
    int unsigned mismatch_count;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [31:0] hold_cfg = HOLD_TIME_RESET;
    logic [31:0] debounce_cfg = DEBOUNCE_TIME_RESET;
    logic [31:0] stamp_ms = '0;
    int unsigned items_sent = 0;

    debounced_press_hold_detector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    press_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending_events (pending_events),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic lvl, input logic [31:0] now);
        item_t req;
        req.pressed = lvl;
        req.now_ms  = now;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic tap(input logic lvl, input logic [31:0] delta);
        stamp_ms = stamp_ms + delta;
        send_item(lvl, stamp_ms);
        items_sent++;
    endtask

    task automatic send_at(input logic lvl, input logic [31:0] now);
        stamp_ms = now;
        tap(lvl, 32'd0);
    endtask

    function automatic logic [31:0] step_near(input logic [31:0] span);
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return span - 32'd1;
            2: return span;
            3: return span + 32'd1;
            default: return $urandom_range(span);
        endcase
    endfunction

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_events != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [31:0] hold, input logic [31:0] debounce);
        settle();
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_DEBOUNCE_TIME, debounce);
        hold_cfg     = hold;
        debounce_cfg = debounce;
    endtask

    initial
    begin
        int pick;
        int bounces;
        int steps;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 62;

        send_at(1'b0, 32'd0);
        send_at(1'b1, 32'd100);
        send_at(1'b1, 32'd120);
        send_at(1'b1, 32'd3119);
        send_at(1'b1, 32'd3120);
        send_at(1'b0, 32'd3130);
        send_at(1'b0, 32'd3150);
        send_at(1'b1, 32'd4000);
        send_at(1'b1, 32'd4020);
        send_at(1'b0, 32'd4500);
        send_at(1'b1, 32'd4505);
        send_at(1'b0, 32'd4510);
        send_at(1'b0, 32'd4530);
        send_at(1'b1, 32'hFFFF_FFF0);
        send_at(1'b1, 32'h0000_0004);
        send_at(1'b1, 32'h0000_0BBC);
        send_at(1'b0, 32'hFFFF_FFFF);

        set_timing(32'd0, 32'd0);
        send_at(1'b0, 32'h1234_5678);
        send_at(1'b1, 32'hEDCB_A987);

        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_at(1'b0, 32'd0);
        send_at(1'b0, 32'hFFFF_FFFF);
        send_at(1'b1, 32'h0000_0010);
        send_at(1'b1, 32'h0000_000F);

        set_timing(32'd256000, 32'd5);
        send_at(1'b0, 32'd100);
        send_at(1'b0, 32'd105);
        send_at(1'b1, 32'd200);
        send_at(1'b1, 32'd205);
        send_at(1'b1, 32'd1206);
        send_at(1'b1, 32'd2205);

        for (int seg = 0; seg < 13; seg++)
        begin
            if (seg == 5)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 17;
            end
            else if (seg == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg % 6)
                0: set_timing(HOLD_TIME_RESET, DEBOUNCE_TIME_RESET);
                1: set_timing($urandom_range(5000), $urandom_range(50));
                2: set_timing(32'd0, 32'd0);
                3: set_timing($urandom, $urandom);
                4: set_timing(32'd256000, $urandom_range(10));
                default: set_timing(32'hFFFF_FFFF, $urandom_range(20));
            endcase
            stamp_ms   = $urandom;
            items_sent = 0;
            while (items_sent < 150)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    bounces = $urandom_range(3);
                    for (int i = 0; i < bounces; i++)
                    begin
                        tap(i % 2 == 0, step_near(debounce_cfg >> 1));
                    end
                    tap(1'b1, step_near(debounce_cfg));
                    steps = $urandom_range(1, 5);
                    for (int i = 0; i < steps; i++)
                    begin
                        tap(1'b1, step_near(hold_cfg >> $urandom_range(2)));
                    end
                    bounces = $urandom_range(3);
                    for (int i = 0; i < bounces; i++)
                    begin
                        tap(i % 2 == 1, step_near(debounce_cfg >> 1));
                    end
                    tap(1'b0, step_near(debounce_cfg));
                    tap(1'b0, step_near(debounce_cfg));
                end
                else if (pick < 92)
                begin
                    tap($urandom_range(1), $urandom_range(40));
                end
                else
                begin
                    stamp_ms = $urandom;
                    tap($urandom_range(1), 32'd0);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && pending_events == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dphd_pkg.sv
hw/rtl/dphd_countdown.sv
hw/rtl/debounced_press_hold_detector_top.sv
test/press_event_checker.sv
test/debounced_press_hold_detector_top_test.sv
